### design/dbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpe_pkg: shared types and constants
// Command format passed from the pixel front end to the byte back end.
// ----------------------------------------------------------------------------
package dbpe_pkg;

    localparam int unsigned BAND_ROWS  = 24;
    localparam int unsigned CMD_DEPTH  = 4;
    localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
    localparam int unsigned NUM_SLOTS  = 13;

    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_DOT_THRESHOLD = 2'd2;

    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_SPACING = 8'h33;
    localparam logic [7:0] BYTE_24DOT   = 8'h18;
    localparam logic [7:0] BYTE_LF      = 8'h0a;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2a;
    localparam logic [7:0] BYTE_MODE33  = 8'h21;

    localparam logic [15:0] WIDTH_RESET     = 16'd1;
    localparam logic [15:0] HEIGHT_RESET    = 16'd1;
    localparam logic [31:0] THRESHOLD_RESET = 32'hFF808080;

    // One accepted pixel's worth of output bytes
    typedef struct packed {
        logic        head;      // line-spacing head
        logic        hdr;       // band header
        logic [15:0] width;     // width sampled for the band header
        logic [7:0]  dot_byte;  // first dot byte, any further ones are zero
        logic [1:0]  num_dots;  // dot bytes, 0..3
        logic        lf;        // band line feed
        logic        eoi;       // flag last byte as end of image
    } t_cmd;

    typedef struct packed {
        logic                 full;
        logic                 not_empty;
        logic [CMD_CNT_W-1:0] count;
    } t_fifo_status;

endpackage

`default_nettype wire

### design/dbpe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpe_front: pixel classifier
// Thresholds each pixel, tracks band position and builds the byte command.
// ----------------------------------------------------------------------------
module dbpe_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [31:0]   i_pixel_argb,
    input  wire logic [15:0]   i_image_width,
    input  wire logic [15:0]   i_image_height,
    input  wire logic [31:0]   i_dot_threshold,
    output dbpe_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid
);

    logic [4:0]  r_row_in_band,  n_row_in_band;
    logic [7:0]  r_dot_acc,      n_dot_acc;
    logic [15:0] r_column_index, n_column_index;
    logic [16:0] r_band_top_row, n_band_top_row;
    logic        r_image_started, n_image_started;

    logic        band_past;
    logic [15:0] rows_left;
    logic [4:0]  rows_here;
    logic        dot;
    logic [4:0]  row_next;
    logic [7:0]  acc_next;
    logic        end_col;
    logic [15:0] col_next;
    logic        band_end;
    logic [16:0] top_next;
    logic        last;

    always_comb begin
        band_past = r_band_top_row >= {1'b0, i_image_height};
        rows_left = i_image_height - r_band_top_row[15:0];
        if (band_past) begin
            rows_here = 5'd0;
        end else if (rows_left >= 16'(dbpe_pkg::BAND_ROWS)) begin
            rows_here = 5'(dbpe_pkg::BAND_ROWS);
        end else begin
            rows_here = rows_left[4:0];
        end

        dot      = i_pixel_argb <= i_dot_threshold;
        row_next = r_row_in_band + 5'd1;
        acc_next = {r_dot_acc[6:0], dot};
        end_col  = (row_next >= rows_here) || (row_next >= 5'(dbpe_pkg::BAND_ROWS));
        col_next = r_column_index + 16'd1;
        band_end = end_col && ((col_next >= i_image_width) || (col_next == 16'd0));
        top_next = r_band_top_row + 17'(dbpe_pkg::BAND_ROWS);
        last     = band_end && (top_next >= {1'b0, i_image_height});

        o_cmd.head  = !r_image_started;
        o_cmd.hdr   = (r_column_index == 16'd0) && (r_row_in_band == 5'd0);
        o_cmd.width = i_image_width;
        o_cmd.lf    = band_end && !last;
        o_cmd.eoi   = last;
        if (end_col) begin
            o_cmd.dot_byte = acc_next << (3'd7 - r_row_in_band[2:0]);
            o_cmd.num_dots = 2'd3 - r_row_in_band[4:3];
        end else begin
            o_cmd.dot_byte = acc_next;
            o_cmd.num_dots = (row_next[2:0] == 3'd0) ? 2'd1 : 2'd0;
        end
        o_cmd_valid = i_accept && (o_cmd.head || o_cmd.hdr || (o_cmd.num_dots != 2'd0));

        n_row_in_band   = r_row_in_band;
        n_dot_acc       = r_dot_acc;
        n_column_index  = r_column_index;
        n_band_top_row  = r_band_top_row;
        n_image_started = r_image_started;
        if (i_accept) begin
            n_image_started = !last;
            if (end_col) begin
                n_row_in_band  = 5'd0;
                n_dot_acc      = 8'd0;
                n_column_index = band_end ? 16'd0 : col_next;
            end else begin
                n_row_in_band = row_next;
                n_dot_acc     = (row_next[2:0] == 3'd0) ? 8'd0 : acc_next;
            end
            if (band_end) begin
                n_band_top_row = last ? 17'd0 : top_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_in_band   <= 5'd0;
            r_dot_acc       <= 8'd0;
            r_column_index  <= 16'd0;
            r_band_top_row  <= 17'd0;
            r_image_started <= 1'b0;
        end else begin
            r_row_in_band   <= n_row_in_band;
            r_dot_acc       <= n_dot_acc;
            r_column_index  <= n_column_index;
            r_band_top_row  <= n_band_top_row;
            r_image_started <= n_image_started;
        end
    end

endmodule

`default_nettype wire

### design/dbpe_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpe_cmd_fifo: command queue
// Small FIFO decoupling the pixel front end from the byte back end.
// ----------------------------------------------------------------------------
module dbpe_cmd_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  dbpe_pkg::t_cmd         i_wr_cmd,
    input  wire logic              i_rd,
    output dbpe_pkg::t_cmd         o_rd_cmd,
    output dbpe_pkg::t_fifo_status o_status
);

    dbpe_pkg::t_cmd r_mem [dbpe_pkg::CMD_DEPTH];

    logic [dbpe_pkg::CMD_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [dbpe_pkg::CMD_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rd_cmd           = r_mem[r_rd_ptr];
    assign o_status.full      = r_count == dbpe_pkg::CMD_CNT_W'(dbpe_pkg::CMD_DEPTH);
    assign o_status.not_empty = r_count != '0;
    assign o_status.count     = r_count;

endmodule

`default_nettype wire

### design/dbpe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbpe_back: byte sequencer
// Expands each command into its bytes, one per cycle while the output stage is free.
// ----------------------------------------------------------------------------
module dbpe_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  dbpe_pkg::t_cmd i_cmd,
    input  wire logic      i_cmd_avail,
    output logic           o_cmd_take,
    input  wire logic      i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_end_of_image
);

    dbpe_pkg::t_cmd                   r_cmd;
    logic [dbpe_pkg::NUM_SLOTS-1:0]   r_mask;
    logic                             r_out_valid;
    logic [7:0]                       r_out_byte;
    logic                             r_out_eoi;

    logic [7:0]                       slot_byte [dbpe_pkg::NUM_SLOTS];
    logic [dbpe_pkg::NUM_SLOTS-1:0]   load_mask;
    logic [dbpe_pkg::NUM_SLOTS-1:0]   pick;
    logic [dbpe_pkg::NUM_SLOTS-1:0]   rest;
    logic [7:0]                       sel_byte;
    logic                             out_free;
    logic                             advance;

    always_comb begin
        slot_byte[0]  = dbpe_pkg::BYTE_ESC;
        slot_byte[1]  = dbpe_pkg::BYTE_SPACING;
        slot_byte[2]  = dbpe_pkg::BYTE_24DOT;
        slot_byte[3]  = dbpe_pkg::BYTE_LF;
        slot_byte[4]  = dbpe_pkg::BYTE_ESC;
        slot_byte[5]  = dbpe_pkg::BYTE_IMAGE;
        slot_byte[6]  = dbpe_pkg::BYTE_MODE33;
        slot_byte[7]  = r_cmd.width[7:0];
        slot_byte[8]  = r_cmd.width[15:8];
        slot_byte[9]  = r_cmd.dot_byte;
        slot_byte[10] = 8'h00;
        slot_byte[11] = 8'h00;
        slot_byte[12] = dbpe_pkg::BYTE_LF;

        load_mask = {i_cmd.lf,
                     i_cmd.num_dots == 2'd3,
                     i_cmd.num_dots >= 2'd2,
                     i_cmd.num_dots != 2'd0,
                     {5{i_cmd.hdr}},
                     {4{i_cmd.head}}};

        pick     = r_mask & (~r_mask + 1'b1);
        rest     = r_mask & ~pick;
        sel_byte = 8'h00;
        for (int i = 0; i < dbpe_pkg::NUM_SLOTS; i++) begin
            sel_byte = sel_byte | (slot_byte[i] & {8{pick[i]}});
        end

        out_free   = !r_out_valid || i_pop;
        advance    = out_free && (r_mask != '0);
        o_cmd_take = i_cmd_avail && ((r_mask == '0) || (advance && (rest == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (advance) begin
            r_out_byte <= sel_byte;
            r_out_eoi  <= r_cmd.eoi && (rest == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_mask <= load_mask;
            end else if (advance) begin
                r_mask <= rest;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_image = r_out_eoi;

endmodule

`default_nettype wire

### design/dot_band_printer_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a pixel's first byte passes the command queue, the back end's command register
// and its output register. Throughput: one pixel per cycle until the queue is full;
// the back end sends one byte per cycle while output is free, so a pixel with head,
// band header, dots and LF (up to 13 bytes) holds it while the 4-entry queue fills.
// Reset (synchronous, active low) empties the queue and output and restores
// width 1, height 1, threshold 0xFF808080, at the start of a new image.
// ----------------------------------------------------------------------------
// dot_band_printer_encoder_core: 24-dot band printer encoder
// Converts band-ordered ARGB pixels into a bit-image printer command stream.
// ----------------------------------------------------------------------------
module dot_band_printer_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] i_pixel_argb,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_end_of_image
);

    logic [15:0] r_image_width;
    logic [15:0] r_image_height;
    logic [31:0] r_dot_threshold;

    dbpe_pkg::t_cmd         front_cmd;
    logic                   front_cmd_valid;
    dbpe_pkg::t_cmd         fifo_cmd;
    dbpe_pkg::t_fifo_status fifo_status;
    logic                   cmd_take;
    logic                   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= dbpe_pkg::WIDTH_RESET;
            r_image_height  <= dbpe_pkg::HEIGHT_RESET;
            r_dot_threshold <= dbpe_pkg::THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                dbpe_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_wdata[15:0];
                dbpe_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_wdata[15:0];
                dbpe_pkg::CFG_DOT_THRESHOLD: r_dot_threshold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign full   = fifo_status.full;
    assign accept = push && !fifo_status.full;

    dbpe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_pixel_argb    (i_pixel_argb),
        .i_image_width   (r_image_width),
        .i_image_height  (r_image_height),
        .i_dot_threshold (r_dot_threshold),
        .o_cmd           (front_cmd),
        .o_cmd_valid     (front_cmd_valid)
    );

    dbpe_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_cmd_valid),
        .i_wr_cmd (front_cmd),
        .i_rd     (cmd_take),
        .o_rd_cmd (fifo_cmd),
        .o_status (fifo_status)
    );

    dbpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (fifo_cmd),
        .i_cmd_avail    (fifo_status.not_empty),
        .o_cmd_take     (cmd_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_end_of_image (o_end_of_image)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(front_cmd_valid && fifo_status.full && !cmd_take))
        else $error("command queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_status.count <= dbpe_pkg::CMD_CNT_W'(dbpe_pkg::CMD_DEPTH))
        else $error("command queue count out of range");

    a_take_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> fifo_status.not_empty)
        else $error("command taken from empty queue");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result lost");
`endif

endmodule

`default_nettype wire
